// ----- design/number_pool_allocator_core_defines.svh -----
// Assertion macros shared by the number pool allocator RTL.
// Each macro expects a clock named clk and a reset named rst in the using module.
`ifndef NUMBER_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define NUMBER_POOL_ALLOCATOR_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define NPA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define NPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies the consequent in the same cycle.
`define NPA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/npa_pkg.sv -----
// Package for the number pool allocator: request and result types,
// opcodes, controller states and default sizes. No dependencies.
package npa_pkg;

  // Fixed field widths of the request, result and configuration data.
  localparam int NUM_W = 10;
  localparam int OP_W  = 2;
  localparam int CFG_W = 11;

  // Default pool capacity and pool size after reset.
  localparam int DEF_POOL_CAPACITY = 1024;
  localparam logic [CFG_W-1:0] POOL_SIZE_RESET = 11'd1024;

  // Request opcodes; the fourth code is unused and answers with zeros.
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [NUM_W-1:0] number;
  } npa_req_t;

  typedef struct packed {
    logic [NUM_W-1:0] assigned;
    logic             success;
  } npa_rsp_t;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } npa_state_t;

endpackage

// ----- design/npa_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the in-use bitmap and the recycle stack.
module npa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/number_pool_allocator_core.sv -----
// Top level of the number pool allocator: controller, pool size register,
// counters and output register. Depends on npa_pkg, npa_ram and the defines header.
//
// Usage:
//   Requests arrive on in_valid/in_ready/in_data (opcode and number). Results
//   leave on out_valid/out_ready/out_data (assigned and success), one result
//   for every request, in order. The pool size register is written through
//   cfg_valid/cfg_ready/cfg_data, which is always ready.
//   In the cycle a request is accepted the in-use bitmap and the top of the
//   recycle stack are read; then, in the S_EXEC state and once the output
//   register is free, the result is formed, the bitmap and stack are written
//   back, the result register is loaded and out_valid rises. No new request
//   is taken until the current one completes, because of the read-then-write
//   turn of the bitmap and stack memories, which are not bypassed.
//   If the receiver stalls, the result waits in the output register and the
//   next request is still accepted and read; it completes once the output
//   register is free.
//   Reset empties the stack, zeroes the high-water count and sets the pool size
//   to 1024. The bitmap needs no clearing pass: entries at or above the
//   high-water count read as free, so requests are accepted right after reset.
`include "number_pool_allocator_core_defines.svh"

module number_pool_allocator_core
  import npa_pkg::*;
#(
  parameter int POOL_CAPACITY = DEF_POOL_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  npa_req_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output npa_rsp_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(POOL_CAPACITY);
  localparam int CNT_W = $clog2(POOL_CAPACITY + 1);
  localparam int SZ_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int WW    = (IDX_W > NUM_W) ? IDX_W : NUM_W;
  localparam logic [SZ_W-1:0]  CAP_SZ  = SZ_W'(POOL_CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(POOL_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  npa_state_t       state;
  npa_req_t         req;
  logic [CFG_W-1:0] pool_size;
  logic [CNT_W-1:0] stack_depth;
  logic [CNT_W-1:0] high_water;

  logic             accept;
  logic             fire;
  logic [SZ_W-1:0]  size_eff;
  logic [SZ_W-1:0]  num_sz;
  logic [SZ_W-1:0]  hw_sz;
  logic [WW-1:0]    num_wide;
  logic [IDX_W-1:0] num_idx;
  logic [CNT_W-1:0] depth_dec;
  logic             in_range;
  logic             used;

  logic             bm_we;
  logic [IDX_W-1:0] bm_waddr;
  logic             bm_wdata;
  logic             bm_rdata;
  logic             stk_we;
  logic [IDX_W-1:0] stk_rdata;
  logic [WW-1:0]    stk_wide;

  logic [CNT_W-1:0] stack_depth_next;
  logic [CNT_W-1:0] high_water_next;
  npa_rsp_t         rsp_next;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign fire      = (state == S_EXEC) && (!out_valid || out_ready);

  // Effective pool size, clamped to the capacity.
  always_comb begin
    size_eff = SZ_W'(pool_size);
    if (size_eff > CAP_SZ) begin
      size_eff = CAP_SZ;
    end
  end

  // Number of the held request in the widths used for compares and indexing.
  assign num_sz    = SZ_W'(req.number);
  assign hw_sz     = SZ_W'(high_water);
  assign num_wide  = WW'(req.number);
  assign num_idx   = num_wide[IDX_W-1:0];
  assign in_range  = num_sz < size_eff;
  assign depth_dec = stack_depth - CNT_ONE;
  assign stk_wide  = WW'(stk_rdata);

  // Bitmap entries at or above the high-water count were never written.
  assign used = (num_sz < hw_sz) && bm_rdata;

  // Result and state update of the request in execution.
  always_comb begin
    stack_depth_next = stack_depth;
    high_water_next  = high_water;
    rsp_next         = '0;
    bm_we            = 1'b0;
    bm_waddr         = num_idx;
    bm_wdata         = 1'b0;
    stk_we           = 1'b0;
    case (req.opcode)
      OP_ALLOC: begin
        if (stack_depth != '0) begin
          bm_waddr          = stk_rdata;
          bm_wdata          = 1'b1;
          bm_we             = fire;
          stack_depth_next  = depth_dec;
          rsp_next.assigned = stk_wide[NUM_W-1:0];
          rsp_next.success  = 1'b1;
        end else if (hw_sz < size_eff) begin
          bm_waddr          = high_water[IDX_W-1:0];
          bm_wdata          = 1'b1;
          bm_we             = fire;
          high_water_next   = high_water + CNT_ONE;
          rsp_next.assigned = NUM_W'(high_water);
          rsp_next.success  = 1'b1;
        end
      end
      OP_CHECK: begin
        rsp_next.success = in_range && !used;
      end
      OP_RELEASE: begin
        if (in_range && used && (stack_depth < CAP_CNT)) begin
          bm_we            = fire;
          stk_we           = fire;
          stack_depth_next = stack_depth + CNT_ONE;
          rsp_next.success = 1'b1;
        end
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  // Controller, counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      stack_depth <= '0;
      high_water  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fire) begin
        out_valid   <= 1'b1;
        stack_depth <= stack_depth_next;
        high_water  <= high_water_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pool size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= POOL_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pool_size <= cfg_data;
    end
  end

  // Payload registers: held request and result.
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
    if (fire) begin
      out_data <= rsp_next;
    end
  end

  // Request number as a bitmap read address.
  logic [WW-1:0] in_num_wide;
  assign in_num_wide = WW'(in_data.number);

  npa_ram #(
    .WIDTH (1),
    .DEPTH (POOL_CAPACITY)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (accept),
    .raddr (in_num_wide[IDX_W-1:0]),
    .rdata (bm_rdata)
  );

  npa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_CAPACITY)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stack_depth[IDX_W-1:0]),
    .wdata (num_idx),
    .re    (accept),
    .raddr (depth_dec[IDX_W-1:0]),
    .rdata (stk_rdata)
  );

  // Every stacked number was handed out before, so the stack never outgrows it.
  `NPA_ASSERT_ALWAYS(a_depth_le_hw, stack_depth <= high_water, "stack deeper than high water")
  // The high-water count never passes the capacity.
  `NPA_ASSERT_ALWAYS(a_hw_le_cap, high_water <= CAP_CNT, "high water above capacity")
  // A new result appears only when a request completes execution.
  `NPA_ASSERT_IMPLY(a_rsp_from_exec, $rose(out_valid), $past(state == S_EXEC),
                    "result without execution")
  // An accepted request enters the execution state in the following cycle.
  `NPA_ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC, "accepted request not executed")

endmodule

// ----- dv/number_pool_allocator_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for number_pool_allocator_core: drives requests and pool
// size writes over valid/ready channels and checks every result against a scoreboard.
// Depends on npa_pkg and the allocator RTL.

module number_pool_allocator_core_tb;
  import npa_pkg::*;

  // The fourth opcode has no name in the package; it must answer with zeros.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 6;

  // Scoreboard: tracks the pool state and holds the results still owed by the block.
  class alloc_scoreboard;
    logic [CFG_W-1:0] pool_size;
    bit               in_use[DEF_POOL_CAPACITY];
    logic [NUM_W-1:0] recycle[DEF_POOL_CAPACITY];
    int unsigned      depth;
    int unsigned      high_water;
    npa_rsp_t         owed_q[$];
    int               errors;

    function new();
      pool_size = POOL_SIZE_RESET;
      foreach (in_use[i]) in_use[i] = 1'b0;
      foreach (recycle[i]) recycle[i] = '0;
      depth = 0;
      high_water = 0;
      errors = 0;
    endfunction

    function int unsigned eff_size();
      if (pool_size > DEF_POOL_CAPACITY) return DEF_POOL_CAPACITY;
      return 32'(pool_size);
    endfunction

    function void set_pool_size(logic [CFG_W-1:0] v);
      pool_size = v;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Work out the result of an accepted request and update the pool.
    function void note_request(npa_req_t r);
      npa_rsp_t    rsp;
      int unsigned size;
      size = eff_size();
      rsp = '0;
      case (r.opcode)
        OP_ALLOC: begin
          if (depth > 0) begin
            depth--;
            rsp.assigned = recycle[depth];
            in_use[recycle[depth]] = 1'b1;
            rsp.success = 1'b1;
          end else if (high_water < size) begin
            in_use[high_water] = 1'b1;
            rsp.assigned = NUM_W'(high_water);
            high_water++;
            rsp.success = 1'b1;
          end
        end
        OP_CHECK: begin
          if (r.number < size && !in_use[r.number]) rsp.success = 1'b1;
        end
        OP_RELEASE: begin
          if (r.number < size && in_use[r.number] && depth < DEF_POOL_CAPACITY) begin
            in_use[r.number] = 1'b0;
            recycle[depth] = r.number;
            depth++;
            rsp.success = 1'b1;
          end
        end
        default: ;
      endcase
      owed_q.push_back(rsp);
    endfunction

    // Compare one accepted result with the oldest owed result.
    function void check_result(npa_rsp_t got);
      npa_rsp_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result assigned=%0d success=%0b",
                 $time, got.assigned, got.success);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.assigned !== want.assigned) begin
        $display("%0t: assigned mismatch: expected %0d, actual %0d",
                 $time, want.assigned, got.assigned);
        errors++;
      end
      if (got.success !== want.success) begin
        $display("%0t: success mismatch: expected %0b, actual %0b",
                 $time, want.success, got.success);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  npa_req_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  npa_rsp_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  alloc_scoreboard sb = new();

  // Idling controls, set by the main sequence.
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_tokens = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #5 clk = ~clk;

  number_pool_allocator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (hold_seen != hold_tokens) begin
      hold_seen = hold_tokens;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Offer one request, after a random idle gap, and hold it until accepted.
  task automatic send_req(npa_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [NUM_W-1:0] num);
    npa_req_t r;
    r.opcode = op;
    r.number = num;
    send_req(r);
  endtask

  task automatic write_pool_size(logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_pool_size(v);
  endtask

  // Stop offering and wait until every owed result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed traffic: allocates, releases of numbers in use, checks,
  // with some releases of free or out-of-range numbers and the unused opcode.
  function automatic npa_req_t pick_request(int alloc_pct);
    npa_req_t    r;
    int unsigned roll;
    int unsigned size;
    int unsigned start;
    int unsigned idx;
    bit          found;
    size = sb.eff_size();
    r.opcode = OP_ALLOC;
    r.number = NUM_W'($urandom_range(1023));
    roll = $urandom_range(99);
    found = 1'b0;
    if (roll < alloc_pct) begin
      r.opcode = OP_ALLOC;
    end else if (roll < alloc_pct + (100 - alloc_pct) / 2) begin
      r.opcode = OP_RELEASE;
      if (sb.high_water > 0) begin
        start = $urandom_range(sb.high_water - 1);
        for (int i = 0; i < sb.high_water && !found; i++) begin
          idx = (start + i) % sb.high_water;
          if (sb.in_use[idx]) begin
            found = 1'b1;
            r.number = NUM_W'(idx);
          end
        end
      end
    end else if (roll < 95) begin
      r.opcode = $urandom_range(1) ? OP_CHECK : OP_RELEASE;
      if (size > 0 && $urandom_range(1)) r.number = NUM_W'($urandom_range(size - 1));
    end else begin
      r.opcode = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic run_phase(logic [CFG_W-1:0] size, int idle, int stall, int items,
                           int alloc_pct, bit hold_off);
    write_pool_size(size);
    idle_pct = idle;
    stall_pct = stall;
    if (hold_off) hold_tokens++;
    for (int n = 0; n < items; n++) send_req(pick_request(alloc_pct));
    wait_drained();
  endtask

  // Main sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two-number pool: exhaustion, reuse from the stack, bad releases.
    write_pool_size(11'd2);
    send_op(OP_ALLOC, 10'd1023);
    send_op(OP_ALLOC, 10'd0);
    send_op(OP_ALLOC, 10'd512);
    send_op(OP_CHECK, 10'd0);
    send_op(OP_CHECK, 10'd1023);
    send_op(OP_RELEASE, 10'd1);
    send_op(OP_CHECK, 10'd1);
    send_op(OP_RELEASE, 10'd1);
    send_op(OP_RELEASE, 10'd1023);
    send_op(OP_UNUSED, 10'd1023);
    send_op(OP_ALLOC, 10'd0);
    wait_drained();

    // Empty pool: everything fails, even release of a number still in use.
    write_pool_size(11'd0);
    send_op(OP_ALLOC, 10'd0);
    send_op(OP_CHECK, 10'd0);
    send_op(OP_RELEASE, 10'd0);
    send_op(OP_UNUSED, 10'd0);
    wait_drained();

    // Size above capacity is clamped; stack order is last released, first out.
    write_pool_size(11'd2047);
    send_op(OP_CHECK, 10'd1023);
    send_op(OP_RELEASE, 10'd1023);
    send_op(OP_ALLOC, 10'd341);
    send_op(OP_RELEASE, 10'd0);
    send_op(OP_RELEASE, 10'd1);
    send_op(OP_ALLOC, 10'd682);
    send_op(OP_ALLOC, 10'd0);
    wait_drained();

    // Random traffic over several pool sizes and idling patterns.
    run_phase(11'd1, 0, 0, 40, 60, 1'b0);
    run_phase(11'd16, 70, 0, 100, 50, 1'b0);
    run_phase(11'd1024, 0, 70, 120, 65, 1'b1);
    run_phase(11'd12, 28, 28, 100, 40, 1'b0);
    run_phase(11'd2047, 0, 0, 120, 55, 1'b0);
    run_phase(CFG_W'($urandom_range(64, 2)), 28, 28, 120, 45, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      if (sb.pending() != 0) $display("%0t: %0d results never arrived", $time, sb.pending());
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/npa_pkg.sv
design/npa_ram.sv
design/number_pool_allocator_core.sv
dv/number_pool_allocator_core_tb.sv
